[sv/sjs_pkg.sv]
package sjs_pkg;

  localparam int SLOT_W = 8;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic              wr;
    logic              clr;
    logic              dec;
    logic [SLOT_W-1:0] idx;
    logic [15:0]       id;
    logic [15:0]       rel;
    logic [15:0]       size;
  } cell_cmd_t;

  typedef struct packed {
    logic              vld;
    logic              found;
    logic [15:0]       rem;
    logic [15:0]       id;
    logic [SLOT_W-1:0] idx;
  } scan_tok_t;

endpackage

[sv/sjs_cell.sv]
module sjs_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       now_i,
  input  sjs_pkg::cell_cmd_t cmd_i,
  input  sjs_pkg::scan_tok_t tok_i,
  output sjs_pkg::scan_tok_t tok_o
);

  logic               valid_r, valid_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [15:0]        rel_r, rel_nxt;
  logic [15:0]        rem_r, rem_nxt;
  sjs_pkg::scan_tok_t tok_r, tok_nxt;
  logic               hit;
  logic               ready_job;
  logic               take;

  assign hit = (cmd_i.idx == sjs_pkg::SLOT_W'(IDX));

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    rel_nxt   = rel_r;
    rem_nxt   = rem_r;
    if (cmd_i.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd_i.wr && hit) begin
      valid_nxt = 1'b1;
      id_nxt    = cmd_i.id;
      rel_nxt   = cmd_i.rel;
      rem_nxt   = cmd_i.size;
    end else if (cmd_i.dec && hit) begin
      rem_nxt = rem_r - 16'd1;
    end
  end

  // pass the running minimum; strict compare keeps the earliest entry on ties
  assign ready_job = valid_r && (rem_r != 16'd0) && ({16'd0, rel_r} <= now_i);
  assign take      = ready_job && (!tok_i.found || (rem_r < tok_i.rem));

  always_comb begin
    tok_nxt = tok_i;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.rem   = rem_r;
      tok_nxt.id    = id_r;
      tok_nxt.idx   = sjs_pkg::SLOT_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r.vld <= tok_nxt.vld;
    end
    id_r        <= id_nxt;
    rel_r       <= rel_nxt;
    rem_r       <= rem_nxt;
    tok_r.found <= tok_nxt.found;
    tok_r.rem   <= tok_nxt.rem;
    tok_r.id    <= tok_nxt.id;
    tok_r.idx   <= tok_nxt.idx;
  end

  assign tok_o = tok_r;

endmodule

[sv/srpt_job_scheduler_top.sv]
// channel  | handshake          | fields
// ---------+--------------------+--------------------------------------------------
// input    | start & !busy      | in_action, in_job_id, in_release_time, in_job_size
// result   | out_valid (1 cyc)  | out_served_id .. out_load_rejected
//
// Load and clear leave busy low; the result strobes the cycle after acceptance.
// A tick sets busy while a scan transaction walks the cell chain one cell per
// cycle, then the winner is decremented as the result is registered.
// Action 3 leaves busy low and gives no result.
// Synchronous active-low reset empties the table and zeroes time and total.
// The receiver cannot stall; busy alone holds off the sender.
module srpt_job_scheduler_top #(
  parameter int MAX_JOBS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_release_time,
  input  logic [15:0] in_job_size,
  output logic        out_valid,
  output logic [15:0] out_served_id,
  output logic        out_idle_slot,
  output logic        out_job_finished,
  output logic [31:0] out_slot_end_time,
  output logic [31:0] out_completion_sum,
  output logic        out_all_done,
  output logic        out_load_rejected
);

  localparam int CW = $clog2(MAX_JOBS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [CW-1:0]      unfin_r, unfin_nxt;
  logic [31:0]        time_r, time_nxt;
  logic [31:0]        total_r, total_nxt;
  logic               ov_r, ov_nxt;
  logic [15:0]        sid_r, sid_nxt;
  logic               idle_r, idle_nxt;
  logic               fin_r, fin_nxt;
  logic               rej_r, rej_nxt;
  logic               done_r, done_nxt;
  logic               accept;
  logic               scan_end;
  logic               full;
  logic [31:0]        time_inc;
  logic [32:0]        sum_w;
  sjs_pkg::cell_cmd_t cmd;
  sjs_pkg::scan_tok_t tok_w [MAX_JOBS+1];

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign scan_end = (state_r == ST_SCAN) && tok_w[MAX_JOBS].vld;
  assign full     = (fill_r == CW'(MAX_JOBS));
  assign time_inc = (time_r == 32'hFFFF_FFFF) ? time_r : time_r + 32'd1;
  assign sum_w    = {1'b0, total_r} + {1'b0, time_inc};

  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].vld   = accept && (in_action == sjs_pkg::ACT_TICK);
  end

  for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
    sjs_cell #(.IDX(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .now_i (time_r),
      .cmd_i (cmd),
      .tok_i (tok_w[k]),
      .tok_o (tok_w[k+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    unfin_nxt = unfin_r;
    time_nxt  = time_r;
    total_nxt = total_r;
    ov_nxt    = 1'b0;
    sid_nxt   = 16'd0;
    idle_nxt  = 1'b0;
    fin_nxt   = 1'b0;
    rej_nxt   = 1'b0;
    done_nxt  = done_r;
    cmd       = '0;
    cmd.id    = in_job_id;
    cmd.rel   = in_release_time;
    cmd.size  = in_job_size;
    cmd.idx   = sjs_pkg::SLOT_W'(fill_r);
    if (accept) begin
      case (in_action)
        sjs_pkg::ACT_LOAD: begin
          ov_nxt = 1'b1;
          if ((in_job_size == 16'd0) || full) begin
            rej_nxt = 1'b1;
          end else begin
            cmd.wr    = 1'b1;
            fill_nxt  = fill_r + CW'(1);
            unfin_nxt = unfin_r + CW'(1);
          end
          done_nxt = (unfin_nxt == '0);
        end
        sjs_pkg::ACT_TICK: begin
          state_nxt = ST_SCAN;
        end
        sjs_pkg::ACT_CLEAR: begin
          ov_nxt    = 1'b1;
          cmd.clr   = 1'b1;
          fill_nxt  = '0;
          unfin_nxt = '0;
          time_nxt  = 32'd0;
          total_nxt = 32'd0;
          done_nxt  = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (scan_end) begin
      state_nxt = ST_IDLE;
      ov_nxt    = 1'b1;
      time_nxt  = time_inc;
      if (tok_w[MAX_JOBS].found) begin
        cmd.dec = 1'b1;
        cmd.idx = tok_w[MAX_JOBS].idx;
        sid_nxt = tok_w[MAX_JOBS].id;
        if (tok_w[MAX_JOBS].rem == 16'd1) begin
          fin_nxt   = 1'b1;
          unfin_nxt = unfin_r - CW'(1);
          total_nxt = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
        end
      end else begin
        idle_nxt = 1'b1;
      end
      done_nxt = (unfin_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      unfin_r <= '0;
      time_r  <= 32'd0;
      total_r <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      unfin_r <= unfin_nxt;
      time_r  <= time_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
    sid_r  <= sid_nxt;
    idle_r <= idle_nxt;
    fin_r  <= fin_nxt;
    rej_r  <= rej_nxt;
    done_r <= done_nxt;
  end

  assign out_valid          = ov_r;
  assign out_served_id      = sid_r;
  assign out_idle_slot      = idle_r;
  assign out_job_finished   = fin_r;
  assign out_slot_end_time  = time_r;
  assign out_completion_sum = total_r;
  assign out_all_done       = done_r;
  assign out_load_rejected  = rej_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= CW'(MAX_JOBS)) && (unfin_r <= fill_r))
    else $error("fill or unfinished count out of range");

  a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_idle_slot) |-> ((out_served_id == 16'd0) && !out_job_finished))
    else $error("idle slot reports a served job");

  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    scan_end |=> (out_valid && !busy))
    else $error("scan end without tick result");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !tok_w[0].vld)
    else $error("scan transaction injected while busy");
`endif

endmodule
